[design/io_port_decoder_macros.svh]
// assertion macros for the port decoder
`ifndef IO_PORT_DECODER_MACROS_SVH
`define IO_PORT_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define IOPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("io_port_decoder: implication check failed");

// next-cycle implication, checked outside reset
`define IOPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("io_port_decoder: sequence check failed");

`else

`define IOPD_ASSERT_IMP(lbl, ante, cons)
`define IOPD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[design/iopd_pkg.sv]
// types and constants of the port decoder
package iopd_pkg;

  // access kind
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgEnable0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEnable1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEnable2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEnable3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNmiOn   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNmiOff  = 3'd5;

  // configuration reset values
  localparam logic [7:0] Enable0Rst = 8'hFF;
  localparam logic [7:0] Enable1Rst = 8'hFF;
  localparam logic [7:0] Enable2Rst = 8'hFF;
  localparam logic [3:0] Enable3Rst = 4'hF;
  localparam logic [7:0] NmiOnRst   = 8'h3F;
  localparam logic [7:0] NmiOffRst  = 8'hBF;

  // sound chip address masks
  localparam logic [15:0] SndMask    = 16'hC007;
  localparam logic [15:0] SndRegPort = 16'hC005;
  localparam logic [15:0] SndDatPort = 16'h8005;

  // target codes
  localparam logic [5:0] TgtVideo     = 6'd0;
  localparam logic [5:0] TgtI2cSda    = 6'd1;
  localparam logic [5:0] TgtI2cScl    = 6'd2;
  localparam logic [5:0] TgtLayer2    = 6'd3;
  localparam logic [5:0] TgtUartTx    = 6'd4;
  localparam logic [5:0] TgtUartRx    = 6'd5;
  localparam logic [5:0] TgtUartSel   = 6'd6;
  localparam logic [5:0] TgtUartFrame = 6'd7;
  localparam logic [5:0] TgtPage3     = 6'd8;
  localparam logic [5:0] TgtRegSel    = 6'd9;
  localparam logic [5:0] TgtRegData   = 6'd10;
  localparam logic [5:0] TgtPage128   = 6'd11;
  localparam logic [5:0] TgtBankExt   = 6'd12;
  localparam logic [5:0] TgtMouseX    = 6'd13;
  localparam logic [5:0] TgtMouseY    = 6'd14;
  localparam logic [5:0] TgtMouseBtn  = 6'd15;
  localparam logic [5:0] TgtSndReg    = 6'd16;
  localparam logic [5:0] TgtSndData   = 6'd17;
  localparam logic [5:0] TgtNmiOn     = 6'd18;
  localparam logic [5:0] TgtNmiOff    = 6'd19;
  localparam logic [5:0] TgtDma       = 6'd20;
  localparam logic [5:0] TgtJoy1      = 6'd21;
  localparam logic [5:0] TgtJoy2      = 6'd22;
  localparam logic [5:0] TgtSdCtrl    = 6'd23;
  localparam logic [5:0] TgtSpiCs     = 6'd24;
  localparam logic [5:0] TgtSpiData   = 6'd25;
  localparam logic [5:0] TgtVidMode   = 6'd26;
  localparam logic [5:0] TgtDac       = 6'd27;
  localparam logic [5:0] TgtSprSlot   = 6'd28;
  localparam logic [5:0] TgtSprAttr   = 6'd29;
  localparam logic [5:0] TgtSprPat    = 6'd30;
  localparam logic [5:0] TgtFloat     = 6'd31;
  localparam logic [5:0] TgtDrop      = 6'd32;
  localparam logic [5:0] TgtUnhandled = 6'd33;

  // one bus access
  typedef struct packed {
    logic        operation;
    logic [15:0] port_address;
    logic [7:0]  write_data;
  } iopd_req_t;

  // one decode result
  typedef struct packed {
    logic [5:0] target;
    logic [3:0] dac_channels;
    logic [1:0] contention_class;
    logic [7:0] forward_data;
    logic       floating_bus;
  } iopd_rsp_t;

endpackage

[design/io_port_decoder.sv]
// port decoder top level: access register, priority decode, result register
//
//   channel   ports                                   direction  transfer when
//   request   start_i, busy_o, req_i                  in         start_i & !busy_o
//   result    done_o, rsp_o                           out        done_o (one cycle)
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i        in         cfg_we_i
//
// one access per cycle; each transfer passes the access register, then is
// decoded into the result register
// busy_o stays low, the decode has no shared unit to wait for
// the receiver cannot stall: each result is shown for exactly one cycle
// reset restores the enable groups to all ones and the movable nmi ports
// to their default low bytes, and clears both valid flags

`include "io_port_decoder_macros.svh"

module io_port_decoder import iopd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  iopd_req_t          req_i,
  output logic               done_o,
  output iopd_rsp_t          rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  // configuration registers
  logic [7:0] en0_q, en1_q, en2_q, nmi_on_q, nmi_off_q;
  logic [3:0] en3_q;

  // pipeline registers
  logic      req_vld_q;
  iopd_req_t req_q;
  logic      done_q;
  iopd_rsp_t rsp_q;
  iopd_rsp_t rsp_d;

  // decode terms
  logic        wr;
  logic [15:0] addr;
  logic [7:0]  lo;
  logic [5:0]  tgt;
  logic [3:0]  ch;
  logic        exact_hit;
  logic        dac_en;

  // pick the device when enabled, else floating bus on reads, drop on writes
  function automatic logic [5:0] gate(input logic en, input logic [5:0] code,
                                      input logic is_wr);
    logic [5:0] res;
    if (en) begin
      res = code;
    end else if (is_wr) begin
      res = TgtDrop;
    end else begin
      res = TgtFloat;
    end
    return res;
  endfunction

  assign busy_o = 1'b0;

  // configuration writes, indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en0_q     <= Enable0Rst;
      en1_q     <= Enable1Rst;
      en2_q     <= Enable2Rst;
      en3_q     <= Enable3Rst;
      nmi_on_q  <= NmiOnRst;
      nmi_off_q <= NmiOffRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEnable0: en0_q     <= cfg_wdata_i;
        CfgEnable1: en1_q     <= cfg_wdata_i;
        CfgEnable2: en2_q     <= cfg_wdata_i;
        CfgEnable3: en3_q     <= cfg_wdata_i[3:0];
        CfgNmiOn:   nmi_on_q  <= cfg_wdata_i;
        CfgNmiOff:  nmi_off_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // access register: takes a transfer in every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  assign wr   = (req_q.operation == OpWrite);
  assign addr = req_q.port_address;
  assign lo   = addr[7:0];

  // priority decode of one access
  always_comb begin
    tgt       = TgtFloat;
    ch        = '0;
    exact_hit = 1'b1;
    dac_en    = 1'b0;
    if (!addr[0]) begin
      // every even address belongs to the video chip
      tgt = TgtVideo;
    end else if (!wr) begin
      case (addr)
        16'h113B: tgt = gate(en1_q[2], TgtI2cSda,   1'b0);
        16'h123B: tgt = gate(en1_q[7], TgtLayer2,   1'b0);
        16'h133B: tgt = gate(en1_q[4], TgtUartTx,   1'b0);
        16'h143B: tgt = gate(en1_q[4], TgtUartRx,   1'b0);
        16'h153B: tgt = gate(en1_q[4], TgtUartSel,  1'b0);
        16'h163B: tgt = gate(en1_q[4], TgtUartFrame, 1'b0);
        16'h1FFD: tgt = gate(en0_q[3], TgtPage3,    1'b0);
        16'h243B: tgt = TgtRegSel;
        16'h253B: tgt = TgtRegData;
        16'h7FFD: tgt = gate(en0_q[1], TgtPage128,  1'b0);
        16'hDFFD: tgt = gate(en0_q[2], TgtBankExt,  1'b0);
        16'hFBDF: tgt = gate(en1_q[5], TgtMouseX,   1'b0);
        16'hFFDF: tgt = gate(en1_q[5], TgtMouseY,   1'b0);
        16'hFADF: tgt = gate(en1_q[5], TgtMouseBtn, 1'b0);
        default:  exact_hit = 1'b0;
      endcase
      if (!exact_hit) begin
        if ((addr & SndMask) == SndRegPort) begin
          tgt = gate(en2_q[0], TgtSndReg, 1'b0);
        end else if (lo == nmi_on_q) begin
          tgt = gate(en1_q[1], TgtNmiOn, 1'b0);
        end else if (lo == nmi_off_q) begin
          tgt = gate(en1_q[1], TgtNmiOff, 1'b0);
        end else begin
          case (lo)
            8'h0B:   tgt = gate(en3_q[1], TgtDma,     1'b0);
            8'h1F:   tgt = gate(en0_q[6], TgtJoy1,    1'b0);
            8'h37:   tgt = gate(en0_q[7], TgtJoy2,    1'b0);
            8'h6B:   tgt = gate(en0_q[5], TgtDma,     1'b0);
            8'hE3:   tgt = gate(en1_q[0], TgtSdCtrl,  1'b0);
            8'hE7:   tgt = gate(en1_q[3], TgtSpiCs,   1'b0);
            8'hEB:   tgt = gate(en1_q[3], TgtSpiData, 1'b0);
            8'hFF:   tgt = gate(en0_q[0], TgtVidMode, 1'b0);
            default: tgt = TgtFloat;
          endcase
        end
      end
    end else begin
      case (addr)
        16'h103B: tgt = gate(en1_q[2], TgtI2cScl,   1'b1);
        16'h113B: tgt = gate(en1_q[2], TgtI2cSda,   1'b1);
        16'h123B: tgt = gate(en1_q[7], TgtLayer2,   1'b1);
        16'h133B: tgt = gate(en1_q[4], TgtUartTx,   1'b1);
        16'h143B: tgt = gate(en1_q[4], TgtUartRx,   1'b1);
        16'h153B: tgt = gate(en1_q[4], TgtUartSel,  1'b1);
        16'h163B: tgt = gate(en1_q[4], TgtUartFrame, 1'b1);
        16'h1FFD: tgt = gate(en0_q[3], TgtPage3,    1'b1);
        16'h243B: tgt = TgtRegSel;
        16'h253B: tgt = TgtRegData;
        16'h303B: tgt = gate(en1_q[6], TgtSprSlot,  1'b1);
        16'h7FFD: tgt = gate(en0_q[1], TgtPage128,  1'b1);
        16'hDFFD: tgt = gate(en0_q[2], TgtBankExt,  1'b1);
        default:  exact_hit = 1'b0;
      endcase
      if (!exact_hit) begin
        // movable nmi ports only take part while the nmi unit is on
        if (en1_q[1] && lo == nmi_on_q) begin
          tgt = TgtNmiOn;
        end else if (en1_q[1] && lo == nmi_off_q) begin
          tgt = TgtNmiOff;
        end else if ((addr & SndMask) == SndRegPort) begin
          tgt = gate(en2_q[0], TgtSndReg, 1'b1);
        end else if ((addr & SndMask) == SndDatPort) begin
          tgt = gate(en2_q[0], TgtSndData, 1'b1);
        end else begin
          case (lo)
            8'h0B: tgt = gate(en3_q[1], TgtDma,     1'b1);
            8'h6B: tgt = gate(en0_q[5], TgtDma,     1'b1);
            8'hE3: tgt = gate(en1_q[0], TgtSdCtrl,  1'b1);
            8'hE7: tgt = gate(en1_q[3], TgtSpiCs,   1'b1);
            8'hEB: tgt = gate(en1_q[3], TgtSpiData, 1'b1);
            8'hFF: tgt = gate(en0_q[0], TgtVidMode, 1'b1);
            8'h0F: begin dac_en = en2_q[1] | en2_q[4]; ch = 4'h2; end
            8'h1F: begin dac_en = en2_q[1];            ch = 4'h1; end
            8'h3F: begin dac_en = en2_q[3];            ch = 4'h1; end
            8'h4F: begin dac_en = en2_q[1] | en2_q[4]; ch = 4'h4; end
            8'h5F: begin dac_en = en2_q[1] | en2_q[3]; ch = 4'h8; end
            8'hB3: begin dac_en = en2_q[6];            ch = 4'h6; end
            8'hDF: begin dac_en = en2_q[7];            ch = 4'h9; end
            8'hF1: begin dac_en = en2_q[2];            ch = 4'h1; end
            8'hF3: begin dac_en = en2_q[2];            ch = 4'h2; end
            8'hF9: begin dac_en = en2_q[2];            ch = 4'h4; end
            8'hFB: begin dac_en = en2_q[2] | en2_q[5]; ch = 4'h9; end
            8'h57: tgt = gate(en1_q[6], TgtSprAttr, 1'b1);
            8'h5B: tgt = gate(en1_q[6], TgtSprPat,  1'b1);
            default: tgt = TgtUnhandled;
          endcase
          // dac ports: the channel mask only shows on an enabled write
          if (ch != 4'h0) begin
            tgt = dac_en ? TgtDac : TgtDrop;
            if (!dac_en) begin
              ch = 4'h0;
            end
          end
        end
      end
    end
  end

  // result fields
  always_comb begin
    rsp_d.target       = tgt;
    rsp_d.dac_channels = ch;
    // contended range is high byte 0x40..0x7f
    if (addr[15:14] == 2'b01) begin
      rsp_d.contention_class = {1'b1, addr[0]};
    end else begin
      rsp_d.contention_class = {1'b0, ~addr[0]};
    end
    rsp_d.forward_data = (wr && tgt < TgtFloat) ? req_q.write_data : 8'h00;
    rsp_d.floating_bus = ~wr & (tgt == TgtFloat);
  end

  // result register: strobe for one cycle per access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // every transfer yields one result, through the access and result registers
  `IOPD_ASSERT_NXT(a_result_follows, start_i && !busy_o, ##1 done_o)
  // floating bus only on a read that falls through to the floating target
  `IOPD_ASSERT_IMP(a_float_target, done_o && rsp_o.floating_bus, rsp_o.target == TgtFloat)
  // a channel mask only comes with a dac write
  `IOPD_ASSERT_IMP(a_dac_mask, done_o && rsp_o.dac_channels != 4'h0, rsp_o.target == TgtDac)
  // forwarded data only toward a real device
  `IOPD_ASSERT_IMP(a_fwd_device, done_o && rsp_o.forward_data != 8'h00,
                   rsp_o.target < TgtFloat)

endmodule
